FILE: src/mono_page_framebuffer_glyph_blit_top_defines.svh
// ----------------------------------------------------------------------------
// mono page framebuffer glyph blit assertion macros
// concurrent assertion wrappers, clocked on clk
// ----------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_GLYPH_BLIT_TOP_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_GLYPH_BLIT_TOP_DEFINES_SVH

// checked outside reset only
`define MPFGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define MPFGB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/mpfgb_pkg.sv
// ----------------------------------------------------------------------------
// mpfgb_pkg
// shared types, codes and defaults of the glyph blitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpfgb_pkg;

  localparam int DEF_PANEL_WIDTH  = 96;
  localparam int DEF_PANEL_HEIGHT = 32;

  localparam int S_TDATA_W   = 40;
  localparam int S_TUSER_W   = 3;
  localparam int M_TDATA_W   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CFG_NARROW_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_NARROW_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_WIDE_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_WIDE_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_BG_FILL       = 3'd4;

  localparam logic [2:0] FUNC_POINT = 3'd0;
  localparam logic [2:0] FUNC_BEGIN = 3'd1;
  localparam logic [2:0] FUNC_BYTE  = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [4:0] RST_NARROW_WIDTH  = 5'd8;
  localparam logic [5:0] RST_NARROW_HEIGHT = 6'd16;
  localparam logic [4:0] RST_WIDE_WIDTH    = 5'd16;
  localparam logic [5:0] RST_WIDE_HEIGHT   = 6'd16;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PIXELS,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] bits;
    logic [3:0] count;
    logic       wr_zero;
    logic       done;
    logic       status;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic       done;
    logic [7:0] read_data;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_PIX,
    BK_MOD,
    BK_READ,
    BK_CLR,
    BK_FIN
  } bk_state_t;

endpackage

`default_nettype wire

FILE: src/mpfgb_front.sv
// ----------------------------------------------------------------------------
// mpfgb_front
// accepts beats, holds config and glyph cursor, emits commands to the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpfgb_front #(
  parameter int PANEL_WIDTH  = mpfgb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mpfgb_pkg::DEF_PANEL_HEIGHT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [mpfgb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mpfgb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [mpfgb_pkg::S_TDATA_W-1:0]    s_tdata,
  input  wire logic [mpfgb_pkg::S_TUSER_W-1:0]    s_tuser,
  input  wire logic                               init_busy,
  input  wire mpfgb_pkg::q_status_t               q_status,
  output logic                                    q_push,
  output mpfgb_pkg::cmd_t                         q_cmd
);

  localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;

  logic [4:0] narrow_width, wide_width;
  logic [5:0] narrow_height, wide_height;
  logic       bg_fill;

  logic [7:0] origin_x, origin_x_next;
  logic [7:0] origin_y, origin_y_next;
  logic [4:0] cursor_column, cursor_column_next;
  logic [5:0] cursor_row, cursor_row_next;
  logic       size_is_wide, size_is_wide_next;
  logic       glyph_active, glyph_active_next;

  logic [7:0] pos_x, pos_y, glyph_byte;
  logic       pixel_color, wide_glyph;
  logic [1:0] read_page;
  logic [6:0] read_column;

  logic [4:0] cur_w, sel_w, col_gap, col_sum;
  logic [5:0] cur_h, sel_h, row_inc;
  logic [3:0] n;
  logic       row_end;

  assign pos_x       = s_tdata[7:0];
  assign pos_y       = s_tdata[15:8];
  assign pixel_color = s_tdata[16];
  assign wide_glyph  = s_tdata[17];
  assign glyph_byte  = s_tdata[25:18];
  assign read_page   = s_tdata[27:26];
  assign read_column = s_tdata[34:28];

  assign s_tready = !init_busy && !q_status.full;
  assign q_push   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_width  <= mpfgb_pkg::RST_NARROW_WIDTH;
      narrow_height <= mpfgb_pkg::RST_NARROW_HEIGHT;
      wide_width    <= mpfgb_pkg::RST_WIDE_WIDTH;
      wide_height   <= mpfgb_pkg::RST_WIDE_HEIGHT;
      bg_fill       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpfgb_pkg::CFG_NARROW_WIDTH:  narrow_width  <= cfg_data[4:0];
        mpfgb_pkg::CFG_NARROW_HEIGHT: narrow_height <= cfg_data[5:0];
        mpfgb_pkg::CFG_WIDE_WIDTH:    wide_width    <= cfg_data[4:0];
        mpfgb_pkg::CFG_WIDE_HEIGHT:   wide_height   <= cfg_data[5:0];
        mpfgb_pkg::CFG_BG_FILL:       bg_fill       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_w   = size_is_wide ? wide_width : narrow_width;
    cur_h   = size_is_wide ? wide_height : narrow_height;
    sel_w   = wide_glyph ? wide_width : narrow_width;
    sel_h   = wide_glyph ? wide_height : narrow_height;
    col_gap = cur_w - cursor_column;
    if (cursor_column >= cur_w) begin
      n = 4'd0;
    end else if (col_gap > 5'd8) begin
      n = 4'd8;
    end else begin
      n = col_gap[3:0];
    end
    col_sum = cursor_column + {1'b0, n};
    row_end = (n == 4'd0) || (col_sum >= cur_w);
    row_inc = cursor_row + 6'd1;
  end

  always_comb begin
    origin_x_next      = origin_x;
    origin_y_next      = origin_y;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    size_is_wide_next  = size_is_wide;
    glyph_active_next  = glyph_active;
    q_cmd              = '0;
    q_cmd.op           = mpfgb_pkg::OP_NONE;
    unique case (s_tuser)
      mpfgb_pkg::FUNC_POINT: begin
        q_cmd.op      = mpfgb_pkg::OP_PIXELS;
        q_cmd.x       = pos_x;
        q_cmd.y       = pos_y;
        q_cmd.bits    = {pixel_color, 7'd0};
        q_cmd.count   = 4'd1;
        q_cmd.wr_zero = 1'b1;
      end
      mpfgb_pkg::FUNC_BEGIN: begin
        origin_x_next      = pos_x;
        origin_y_next      = pos_y;
        size_is_wide_next  = wide_glyph;
        cursor_column_next = 5'd0;
        cursor_row_next    = 6'd0;
        glyph_active_next  = (sel_w != 5'd0) && (sel_h != 6'd0);
        q_cmd.done         = (sel_w == 5'd0) || (sel_h == 6'd0);
      end
      mpfgb_pkg::FUNC_BYTE: begin
        if (!glyph_active) begin
          q_cmd.status = 1'b1;
        end else begin
          q_cmd.op      = mpfgb_pkg::OP_PIXELS;
          q_cmd.x       = origin_x + {3'd0, cursor_column};
          q_cmd.y       = origin_y + {2'd0, cursor_row};
          q_cmd.bits    = glyph_byte;
          q_cmd.count   = n;
          q_cmd.wr_zero = bg_fill;
          cursor_column_next = col_sum;
          if (row_end) begin
            cursor_column_next = 5'd0;
            cursor_row_next    = row_inc;
            if (row_inc >= cur_h) begin
              glyph_active_next = 1'b0;
              cursor_row_next   = 6'd0;
              q_cmd.done        = 1'b1;
            end
          end
        end
      end
      mpfgb_pkg::FUNC_READ: begin
        if (({4'd0, read_page} < 6'(PAGE_COUNT)) &&
            ({2'd0, read_column} < 9'(PANEL_WIDTH))) begin
          q_cmd.op = mpfgb_pkg::OP_READ;
          q_cmd.x  = {1'b0, read_column};
          q_cmd.y  = {3'd0, read_page, 3'd0};
        end else begin
          q_cmd.status = 1'b1;
        end
      end
      mpfgb_pkg::FUNC_CLEAR: begin
        q_cmd.op = mpfgb_pkg::OP_CLEAR;
      end
      default: begin
        q_cmd.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= 8'd0;
      origin_y      <= 8'd0;
      cursor_column <= 5'd0;
      cursor_row    <= 6'd0;
      size_is_wide  <= 1'b0;
      glyph_active  <= 1'b0;
    end else if (q_push) begin
      origin_x      <= origin_x_next;
      origin_y      <= origin_y_next;
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      size_is_wide  <= size_is_wide_next;
      glyph_active  <= glyph_active_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/mpfgb_queue.sv
// ----------------------------------------------------------------------------
// mpfgb_queue
// short command fifo between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpfgb_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire mpfgb_pkg::cmd_t        push_cmd,
  input  wire logic                   pop,
  output mpfgb_pkg::cmd_t             head,
  output mpfgb_pkg::q_status_t        q_status
);

  localparam int DEPTH = mpfgb_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mpfgb_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     fill;

  assign q_status.full  = (fill == (PW+1)'(DEPTH));
  assign q_status.empty = (fill == '0);
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/mpfgb_back.sv
// ----------------------------------------------------------------------------
// mpfgb_back
// frame memory sequencer: pixel read-modify-write, read back, clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpfgb_back #(
  parameter int PANEL_WIDTH  = mpfgb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mpfgb_pkg::DEF_PANEL_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mpfgb_pkg::q_status_t q_status,
  input  wire mpfgb_pkg::cmd_t      q_head,
  output logic                      q_pop,
  output logic                      init_busy,
  output logic                      m_valid,
  input  wire logic                 m_ready,
  output mpfgb_pkg::res_t           m_res
);

  localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_SIZE = PAGE_COUNT * PANEL_WIDTH;
  localparam int AW         = $clog2(STORE_SIZE);

  mpfgb_pkg::bk_state_t state, state_next;
  mpfgb_pkg::cmd_t      cmd;

  logic [7:0]    mem [STORE_SIZE];
  logic [7:0]    mem_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  logic [AW-1:0] clr_addr, pix_addr;
  logic          clr_last;
  logic [3:0]    bit_idx;
  logic [7:0]    px, shifted;
  logic [7:0]    row_mask;
  logic          cur_bit, in_panel, need_write, pix_end, out_free, load_out;

  assign px         = cmd.x + {5'd0, bit_idx[2:0]};
  assign shifted    = cmd.bits << bit_idx[2:0];
  assign cur_bit    = shifted[7];
  assign in_panel   = ({1'b0, px} < 9'(PANEL_WIDTH)) && ({1'b0, cmd.y} < 9'(PANEL_HEIGHT));
  assign need_write = in_panel && (cur_bit || cmd.wr_zero);
  assign pix_end    = (bit_idx == cmd.count);
  assign pix_addr   = AW'(int'(cmd.y[7:3]) * PANEL_WIDTH + int'(px));
  assign row_mask   = 8'd1 << cmd.y[2:0];
  assign clr_last   = (clr_addr == AW'(STORE_SIZE - 1));
  assign out_free   = !m_valid || m_ready;
  assign init_busy  = (state == mpfgb_pkg::BK_INIT);

  always_comb begin
    state_next = state;
    unique case (state)
      mpfgb_pkg::BK_INIT: begin
        if (clr_last) state_next = mpfgb_pkg::BK_IDLE;
      end
      mpfgb_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          unique case (q_head.op)
            mpfgb_pkg::OP_NONE:   state_next = mpfgb_pkg::BK_FIN;
            mpfgb_pkg::OP_PIXELS: state_next = mpfgb_pkg::BK_PIX;
            mpfgb_pkg::OP_READ:   state_next = mpfgb_pkg::BK_READ;
            mpfgb_pkg::OP_CLEAR:  state_next = mpfgb_pkg::BK_CLR;
          endcase
        end
      end
      mpfgb_pkg::BK_PIX: begin
        if (pix_end) begin
          state_next = mpfgb_pkg::BK_FIN;
        end else if (need_write) begin
          state_next = mpfgb_pkg::BK_MOD;
        end
      end
      mpfgb_pkg::BK_MOD:  state_next = mpfgb_pkg::BK_PIX;
      mpfgb_pkg::BK_READ: state_next = mpfgb_pkg::BK_FIN;
      mpfgb_pkg::BK_CLR: begin
        if (clr_last) state_next = mpfgb_pkg::BK_FIN;
      end
      mpfgb_pkg::BK_FIN: begin
        if (out_free) state_next = mpfgb_pkg::BK_IDLE;
      end
      default: state_next = mpfgb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = 8'd0;
    load_out  = 1'b0;
    unique case (state) inside
      mpfgb_pkg::BK_INIT, mpfgb_pkg::BK_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      mpfgb_pkg::BK_IDLE: begin
        q_pop = !q_status.empty;
      end
      mpfgb_pkg::BK_PIX: begin
        mem_re = !pix_end && need_write;
      end
      mpfgb_pkg::BK_MOD: begin
        mem_we    = 1'b1;
        mem_wdata = cur_bit ? (mem_q | row_mask) : (mem_q & ~row_mask);
      end
      mpfgb_pkg::BK_READ: begin
        mem_re = 1'b1;
      end
      mpfgb_pkg::BK_FIN: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[pix_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mpfgb_pkg::BK_INIT;
      clr_addr <= '0;
      m_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mpfgb_pkg::BK_INIT || state == mpfgb_pkg::BK_CLR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
      end
      if (load_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd     <= q_head;
      bit_idx <= 4'd0;
    end else if ((state == mpfgb_pkg::BK_PIX && !pix_end && !need_write) ||
                 state == mpfgb_pkg::BK_MOD) begin
      bit_idx <= bit_idx + 4'd1;
    end
    if (load_out) begin
      m_res.status    <= cmd.status;
      m_res.done      <= cmd.done;
      m_res.read_data <= (cmd.op == mpfgb_pkg::OP_READ) ? mem_q : 8'd0;
    end
  end

endmodule

`default_nettype wire

FILE: src/mono_page_framebuffer_glyph_blit_top.sv
// each beat becomes a queued command; the back end runs one command at a time
//   through its single-port read-modify-write sequencer, visiting glyph pixels in
//   turn: a drawn pixel is read and written back, a skipped one is passed over;
//   the queue takes further beats until it is full; a stalled result holds it
// reset: sync, active high; then a clearing pass over all PAGE_COUNT*PANEL_WIDTH
//   store bytes (384 at 96x32) during which no beat is accepted
// ----------------------------------------------------------------------------
// mono_page_framebuffer_glyph_blit_top
// page organized monochrome frame store with point, read, clear and glyph blit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mono_page_framebuffer_glyph_blit_top #(
  parameter int PANEL_WIDTH  = mpfgb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mpfgb_pkg::DEF_PANEL_HEIGHT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [mpfgb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mpfgb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // pos_x, pos_y, pixel_color, wide_glyph, glyph_byte, read_page, read_column
  input  wire logic [mpfgb_pkg::S_TDATA_W-1:0]   s_tdata,
  // func
  input  wire logic [mpfgb_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // read_data, glyph_done, status
  output logic [mpfgb_pkg::M_TDATA_W-1:0]        m_tdata
);

  mpfgb_pkg::cmd_t      push_cmd, head;
  mpfgb_pkg::q_status_t q_status;
  mpfgb_pkg::res_t      res;
  logic                 push, pop, init_busy;

  mpfgb_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .init_busy(init_busy),
    .q_status (q_status),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  mpfgb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_status(q_status)
  );

  mpfgb_back #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_head   (head),
    .q_pop    (pop),
    .init_busy(init_busy),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_res    (res)
  );

  assign m_tdata = {6'd0, res.status, res.done, res.read_data};

endmodule

`default_nettype wire

FILE: src/mpfgb_checker.sv
// ----------------------------------------------------------------------------
// mpfgb_checker
// port level checks on the glyph blitter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mono_page_framebuffer_glyph_blit_top_defines.svh"

module mpfgb_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [mpfgb_pkg::M_TDATA_W-1:0]   m_tdata
);

  `MPFGB_ASSERT(a_out_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")
  `MPFGB_ASSERT(a_out_data_holds, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")
  `MPFGB_ASSERT_RST(a_reset_quiet, rst |=> !s_tready && !m_tvalid, "active after reset")
  `MPFGB_ASSERT(a_data_zero, m_tvalid && (m_tdata[8] || m_tdata[9]) |-> m_tdata[7:0] == 8'd0, "read data on non-read")

endmodule

bind mono_page_framebuffer_glyph_blit_top mpfgb_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire
